// ===== rtl/dlpg_pkg.sv =====
// dlpg_pkg: shared types and constants for the dda line pixel generator
// depends on nothing; used by every module of the block but dlpg_out_buf
`timescale 1ns / 1ps

package dlpg_pkg;

  localparam int COORD_BITS_DEFAULT = 16;

  // register widths
  localparam int MARGIN_BITS    = 12;
  localparam int SCREEN_BITS    = 14;
  localparam int ADDR_BITS      = 32;
  localparam int PITCH_BITS     = 16;
  localparam int PIX_BITS_W     = 6;
  localparam int COLOR_BITS     = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam int BITS_PER_BYTE = 8;
  localparam int BYTE_SHIFT    = $clog2(BITS_PER_BYTE);
  localparam int STRIDE_BITS   = PIX_BITS_W - BYTE_SHIFT;

  // register reset values
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET   = '0;
  localparam logic [SCREEN_BITS-1:0] WIDTH_RESET    = SCREEN_BITS'(1920);
  localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET   = SCREEN_BITS'(1080);
  localparam logic [ADDR_BITS-1:0]   BASE_RESET     = '0;
  localparam logic [PITCH_BITS-1:0]  PITCH_RESET    = PITCH_BITS'(7680);
  localparam logic [PIX_BITS_W-1:0]  PIX_BITS_RESET = PIX_BITS_W'(32);
  localparam logic [COLOR_BITS-1:0]  COLOR_RESET    = COLOR_BITS'(32'h0000_FF00);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MARGIN        = 3'd0,
    CFG_SCREEN_WIDTH  = 3'd1,
    CFG_SCREEN_HEIGHT = 3'd2,
    CFG_FRAME_BASE    = 3'd3,
    CFG_LINE_PITCH    = 3'd4,
    CFG_PIXEL_BITS    = 3'd5,
    CFG_LINE_COLOR    = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

endpackage

// ===== rtl/dlpg_dda_core.sv =====
// dlpg_dda_core: line state and exact remainder dda stepping, one step per advance before the final step
// depends on dlpg_pkg only for the default coordinate width parameter
`timescale 1ns / 1ps

module dlpg_dda_core #(
  parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic                         advance,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         busy,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic                         frac_x,
  output logic                         frac_y,
  output logic                         final_step
);

  localparam int DW = COORD_BITS + 1;
  localparam int SW = COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] origin [2];
  logic signed [DW-1:0]         delta  [2];
  logic signed [DW-1:0]         offset [2];
  logic signed [DW-1:0]         rem    [2];
  logic        [DW-1:0]         step_total;
  logic        [DW-1:0]         step_index;

  logic signed [DW-1:0]         delta_next  [2];
  logic        [DW-1:0]         mag_next    [2];
  logic signed [DW-1:0]         offset_next [2];
  logic signed [DW-1:0]         rem_next    [2];
  logic signed [SW-1:0]         sum         [2];
  logic signed [SW-1:0]         total_ext;

  assign final_step = step_index >= step_total;
  assign total_ext  = signed'({1'b0, step_total});

  always_comb begin
    delta_next[0] = DW'(end_x) - DW'(start_x);
    delta_next[1] = DW'(end_y) - DW'(start_y);
    for (int a = 0; a < 2; a++) begin
      mag_next[a] = delta_next[a][DW-1] ? DW'(-delta_next[a]) : delta_next[a];
      sum[a]         = SW'(rem[a]) + SW'(delta[a]);
      offset_next[a] = offset[a];
      rem_next[a]    = sum[a][DW-1:0];
      // at most one correction keeps the remainder in [0, steps)
      if (!delta[a][DW-1]) begin
        if (sum[a] >= total_ext) begin
          rem_next[a]    = DW'(sum[a] - total_ext);
          offset_next[a] = offset[a] + DW'(1);
        end
      end else if (sum[a][SW-1]) begin
        rem_next[a]    = DW'(sum[a] + total_ext);
        offset_next[a] = offset[a] - DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      step_total <= '0;
      step_index <= '0;
      for (int a = 0; a < 2; a++) begin
        origin[a] <= '0;
        delta[a]  <= '0;
        offset[a] <= '0;
        rem[a]    <= '0;
      end
    end else if (load) begin
      busy       <= 1'b1;
      origin[0]  <= start_x;
      origin[1]  <= start_y;
      step_total <= (mag_next[0] >= mag_next[1]) ? mag_next[0] : mag_next[1];
      step_index <= '0;
      for (int a = 0; a < 2; a++) begin
        delta[a]  <= delta_next[a];
        offset[a] <= '0;
        rem[a]    <= '0;
      end
    end else if (advance && busy) begin
      if (final_step) begin
        busy <= 1'b0;
      end else begin
        step_index <= step_index + DW'(1);
        for (int a = 0; a < 2; a++) begin
          offset[a] <= offset_next[a];
          rem[a]    <= rem_next[a];
        end
      end
    end
  end

  assign pos_x  = origin[0] + offset[0][COORD_BITS-1:0];
  assign pos_y  = origin[1] + offset[1][COORD_BITS-1:0];
  assign frac_x = rem[0] != '0;
  assign frac_y = rem[1] != '0;

endmodule

// ===== rtl/dlpg_pixel_calc.sv =====
// dlpg_pixel_calc: margin clip and frame buffer byte address of one pixel
// depends on dlpg_pkg for register widths
`timescale 1ns / 1ps

module dlpg_pixel_calc #(
  parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic signed [COORD_BITS-1:0]              pos_x,
  input  logic signed [COORD_BITS-1:0]              pos_y,
  input  logic                                      frac_x,
  input  logic                                      frac_y,
  input  logic        [dlpg_pkg::MARGIN_BITS-1:0]   margin,
  input  logic        [dlpg_pkg::SCREEN_BITS-1:0]   screen_width,
  input  logic        [dlpg_pkg::SCREEN_BITS-1:0]   screen_height,
  input  logic        [dlpg_pkg::ADDR_BITS-1:0]     frame_base,
  input  logic        [dlpg_pkg::PITCH_BITS-1:0]    line_pitch,
  input  logic        [dlpg_pkg::PIX_BITS_W-1:0]    pixel_bits,
  output logic                                      visible,
  output logic        [dlpg_pkg::ADDR_BITS-1:0]     pixel_address
);

  localparam int EDGE_W = dlpg_pkg::SCREEN_BITS + 1;
  localparam int CMP_W  = ((COORD_BITS > EDGE_W) ? COORD_BITS : EDGE_W) + 1;
  localparam int AW     = dlpg_pkg::ADDR_BITS;

  logic signed [EDGE_W-1:0] hi_x, hi_y;
  logic signed [CMP_W-1:0]  px, py, lo, hx, hy;
  logic                     in_x, in_y;
  logic        [AW-1:0]     ux, uy, prod_x, prod_y;
  logic [dlpg_pkg::STRIDE_BITS-1:0] stride;

  // far edge can go negative, which hides the whole axis
  assign hi_x = signed'({1'b0, screen_width})  - EDGE_W'(margin);
  assign hi_y = signed'({1'b0, screen_height}) - EDGE_W'(margin);

  assign px = CMP_W'(pos_x);
  assign py = CMP_W'(pos_y);
  assign lo = CMP_W'(signed'({1'b0, margin}));
  assign hx = CMP_W'(hi_x);
  assign hy = CMP_W'(hi_y);

  // exact position is pos + rem/steps with 0 <= rem < steps
  assign in_x    = ((px > lo) || (px == lo && frac_x)) && (px < hx);
  assign in_y    = ((py > lo) || (py == lo && frac_y)) && (py < hy);
  assign visible = in_x && in_y;

  assign stride = pixel_bits[dlpg_pkg::PIX_BITS_W-1:dlpg_pkg::BYTE_SHIFT];
  assign ux     = AW'(pos_x);
  assign uy     = AW'(pos_y);
  assign prod_y = uy * AW'(line_pitch);
  assign prod_x = ux * AW'(stride);
  assign pixel_address = frame_base + prod_y + prod_x;

endmodule

// ===== rtl/dlpg_out_buf.sv =====
// dlpg_out_buf: two-entry output register with skid slot for the result channel
// depends on nothing beyond its data width parameter
`timescale 1ns / 1ps

module dlpg_out_buf #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              head_valid, spare_valid;
  logic [DATA_W-1:0] head, spare;
  logic              pop;

  assign pop       = head_valid && out_ready;
  assign space     = !spare_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop) begin
      if (spare_valid) begin
        spare_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_valid <= 1'b1;
      end else begin
        spare_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (spare_valid) begin
        head  <= spare;
        spare <= push_data;
      end else begin
        head <= push_data;
      end
    end else if (push) begin
      if (!head_valid) begin
        head <= push_data;
      end else begin
        spare <= push_data;
      end
    end
  end

endmodule

// ===== rtl/dda_line_pixel_generator_unit.sv =====
// dda_line_pixel_generator_unit: top level of the dda line pixel generator
// depends on dlpg_pkg, dlpg_dda_core, dlpg_pixel_calc and dlpg_out_buf
`timescale 1ns / 1ps

// Usage
//   input channel (in_valid/in_ready): operation load latches start and end
//   points and starts a line; operation advance gives the next pixel of the
//   active line, from the start point through the end point inclusive. a load
//   or an advance with no active line gives nothing.
//   output channel (out_valid/out_ready): one transaction per pixel with its
//   coordinates, byte address, colour, visible flag and last flag.
//   configuration: cfg_write_enable writes cfg_write_data to the register
//   selected by cfg_index; write only while the block is idle.
// Timing
//   one item per clock while in_ready is high; an advance transaction
//   registers its pixel into the output buffer. the address multiply-add
//   sits between the line state registers and the output register; the dda
//   step (remainder add with one correction) feeds the line state registers.
//   a two-entry output buffer lets input flow on while a result waits; with
//   the receiver stalled the block takes input until one more pixel is made,
//   then drops in_ready until out_ready returns.
// Reset: rst (synchronous) clears the line state, empties the output buffer
//   and loads the default register values.

module dda_line_pixel_generator_unit #(
  parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write_enable,
  input  logic [dlpg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [dlpg_pkg::CFG_DATA_BITS-1:0]       cfg_write_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     operation,
  input  logic signed [COORD_BITS-1:0]             start_x,
  input  logic signed [COORD_BITS-1:0]             start_y,
  input  logic signed [COORD_BITS-1:0]             end_x,
  input  logic signed [COORD_BITS-1:0]             end_y,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [COORD_BITS-1:0]             pixel_x,
  output logic signed [COORD_BITS-1:0]             pixel_y,
  output logic [dlpg_pkg::ADDR_BITS-1:0]           pixel_address,
  output logic [dlpg_pkg::COLOR_BITS-1:0]          pixel_color,
  output logic                                     visible,
  output logic                                     last
);

  localparam int AW     = dlpg_pkg::ADDR_BITS;
  localparam int CW     = dlpg_pkg::COLOR_BITS;
  localparam int DATA_W = 2 * COORD_BITS + AW + CW + 2;

  logic [dlpg_pkg::MARGIN_BITS-1:0] margin;
  logic [dlpg_pkg::SCREEN_BITS-1:0] screen_width, screen_height;
  logic [AW-1:0]                    frame_base;
  logic [dlpg_pkg::PITCH_BITS-1:0]  line_pitch;
  logic [dlpg_pkg::PIX_BITS_W-1:0]  pixel_bits;
  logic [CW-1:0]                    line_color;

  logic                         accept, load, advance, busy, push;
  logic signed [COORD_BITS-1:0] pos_x, pos_y;
  logic                         frac_x, frac_y, final_step, pix_visible;
  logic [AW-1:0]                pix_address;
  logic [DATA_W-1:0]            push_data, out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin        <= dlpg_pkg::MARGIN_RESET;
      screen_width  <= dlpg_pkg::WIDTH_RESET;
      screen_height <= dlpg_pkg::HEIGHT_RESET;
      frame_base    <= dlpg_pkg::BASE_RESET;
      line_pitch    <= dlpg_pkg::PITCH_RESET;
      pixel_bits    <= dlpg_pkg::PIX_BITS_RESET;
      line_color    <= dlpg_pkg::COLOR_RESET;
    end else if (cfg_write_enable) begin
      unique case (dlpg_pkg::cfg_reg_t'(cfg_index))
        dlpg_pkg::CFG_MARGIN:
          margin <= cfg_write_data[dlpg_pkg::MARGIN_BITS-1:0];
        dlpg_pkg::CFG_SCREEN_WIDTH:
          screen_width <= cfg_write_data[dlpg_pkg::SCREEN_BITS-1:0];
        dlpg_pkg::CFG_SCREEN_HEIGHT:
          screen_height <= cfg_write_data[dlpg_pkg::SCREEN_BITS-1:0];
        dlpg_pkg::CFG_FRAME_BASE:
          frame_base <= cfg_write_data[AW-1:0];
        dlpg_pkg::CFG_LINE_PITCH:
          line_pitch <= cfg_write_data[dlpg_pkg::PITCH_BITS-1:0];
        dlpg_pkg::CFG_PIXEL_BITS:
          pixel_bits <= cfg_write_data[dlpg_pkg::PIX_BITS_W-1:0];
        dlpg_pkg::CFG_LINE_COLOR:
          line_color <= cfg_write_data[CW-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  assign accept  = in_valid && in_ready;
  assign load    = accept && (dlpg_pkg::op_t'(operation) == dlpg_pkg::OP_LOAD);
  assign advance = accept && (dlpg_pkg::op_t'(operation) == dlpg_pkg::OP_ADVANCE);
  assign push    = advance && busy;

  dlpg_dda_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .advance    (advance),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .busy       (busy),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .frac_x     (frac_x),
    .frac_y     (frac_y),
    .final_step (final_step)
  );

  dlpg_pixel_calc #(
    .COORD_BITS(COORD_BITS)
  ) u_calc (
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .frac_x        (frac_x),
    .frac_y        (frac_y),
    .margin        (margin),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .frame_base    (frame_base),
    .line_pitch    (line_pitch),
    .pixel_bits    (pixel_bits),
    .visible       (pix_visible),
    .pixel_address (pix_address)
  );

  assign push_data = {pos_x, pos_y, pix_address, line_color, pix_visible, final_step};

  dlpg_out_buf #(
    .DATA_W(DATA_W)
  ) u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign {pixel_x, pixel_y, pixel_address, pixel_color, visible, last} = out_data;

endmodule

// ===== rtl/dlpg_checker.sv =====
// dlpg_checker: port-level assertions for the dda line pixel generator
// depends on dlpg_pkg; bound to dda_line_pixel_generator_unit below
`timescale 1ns / 1ps

module dlpg_checker #(
  parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEFAULT
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                operation,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [COORD_BITS-1:0]        pixel_x,
  input logic signed [COORD_BITS-1:0]        pixel_y,
  input logic [dlpg_pkg::ADDR_BITS-1:0]      pixel_address,
  input logic [dlpg_pkg::COLOR_BITS-1:0]     pixel_color,
  input logic                                visible,
  input logic                                last
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y) &&
      $stable(pixel_address) && $stable(pixel_color) && $stable(visible) && $stable(last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // input only backs up when a result is waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with output empty");

  // a load transaction into an empty output gives no pixel
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid &&
      (dlpg_pkg::op_t'(operation) == dlpg_pkg::OP_LOAD) |=> !out_valid)
    else $error("load produced a result");

endmodule

bind dda_line_pixel_generator_unit dlpg_checker #(
  .COORD_BITS(COORD_BITS)
) u_dlpg_checker (.*);
